### hdl/lfmc_pkg.sv
// ----------------------------------------------------------------------------
// lfmc_pkg
// shared types, constants and aes helper functions for the frame mic engine
// ----------------------------------------------------------------------------
package lfmc_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam logic [7:0] B0Tag   = 8'h49;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [7:0] RbConst = 8'h87;
   localparam logic [7:0] BlockBytes = 8'd16;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BLOCK = 2'd1,
      OP_FINAL = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type  kind;
      logic [127:0] blk;
      logic         zero_len;
      logic         use_k2;
   } op_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int rw = 0; rw < 4; rw++) begin
            t[rw + 4*c] = sbox(s[127 - 8*(rw + 4*((c + rw) % 4)) -: 8]);
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = t[i];
      end
      return r;
   endfunction

   function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [7:0] rcon);
      logic [7:0] b [16];
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         b[i] = k[127 - 8*i -: 8];
      end
      b[0] = b[0] ^ sbox(b[13]) ^ rcon;
      b[1] = b[1] ^ sbox(b[14]);
      b[2] = b[2] ^ sbox(b[15]);
      b[3] = b[3] ^ sbox(b[12]);
      for (int i = 4; i < 16; i++) begin
         b[i] = b[i] ^ b[i-4];
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8*i -: 8] = b[i];
      end
      return r;
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RbConst : 8'h00)};
   endfunction

endpackage

### hdl/lfmc_front.sv
// ----------------------------------------------------------------------------
// lfmc_front
// accepts request transactions, builds b0 and 16-byte blocks, issues ops
// ----------------------------------------------------------------------------
module lfmc_front import lfmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         req_type,
   input  logic         direction,
   input  logic [31:0]  dev_addr,
   input  logic [15:0]  frame_counter,
   input  logic [7:0]   msg_length,
   input  logic [7:0]   data_byte,
   output logic         op_push,
   output op_type       op
);

   logic         busy_ff, busy_in;
   logic [7:0]   remain_ff, remain_in;
   logic [4:0]   count_ff, count_in;
   logic [127:0] buf_ff, buf_in;
   logic [127:0] b0;
   logic [127:0] padded;
   logic [4:0]   count_inc;
   logic [7:0]   remain_dec;

   always_comb begin
      b0 = {B0Tag, 32'd0, 7'd0, direction, dev_addr[31:24], dev_addr[23:16],
            dev_addr[15:8], dev_addr[7:0], frame_counter[7:0],
            frame_counter[15:8], 24'd0, msg_length};
      buf_in = buf_ff;
      buf_in[127 - 8*count_ff[3:0] -: 8] = data_byte;
      count_inc  = count_ff + 5'd1;
      remain_dec = remain_ff - 8'd1;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < count_inc) begin
            padded[127 - 8*i -: 8] = buf_in[127 - 8*i -: 8];
         end else if (5'(i) == count_inc) begin
            padded[127 - 8*i -: 8] = PadByte;
         end else begin
            padded[127 - 8*i -: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      op_push   = 1'b0;
      op.kind     = OP_BLOCK;
      op.blk      = buf_in;
      op.zero_len = 1'b0;
      op.use_k2   = 1'b0;
      if (accept) begin
         if (req_type == REQ_START) begin
            op_push     = 1'b1;
            op.kind     = OP_START;
            op.blk      = b0;
            op.zero_len = (msg_length == 8'd0);
            busy_in     = (msg_length != 8'd0);
            remain_in   = msg_length;
            count_in    = 5'd0;
         end else if (busy_ff) begin
            remain_in = remain_dec;
            count_in  = count_inc;
            if (remain_dec == 8'd0) begin
               op_push   = 1'b1;
               op.kind   = OP_FINAL;
               op.use_k2 = (count_inc != 5'(BlockBytes));
               op.blk    = op.use_k2 ? padded : buf_in;
               busy_in   = 1'b0;
               count_in  = 5'd0;
            end else if (count_inc == 5'(BlockBytes)) begin
               op_push  = 1'b1;
               op.kind  = OP_BLOCK;
               count_in = 5'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= 8'd0;
         count_ff  <= 5'd0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
      end
      if (accept && req_type == REQ_DATA && busy_ff) begin
         buf_ff <= buf_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < 5'(BlockBytes)) else $error("block byte count overflow");
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> count_ff == 5'd0) else $error("byte count left over when idle");
   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      op_push && op.kind == OP_FINAL |=> !busy_ff) else $error("message still open");

endmodule

### hdl/lfmc_queue.sv
// ----------------------------------------------------------------------------
// lfmc_queue
// short op queue between the front and the back
// ----------------------------------------------------------------------------
module lfmc_queue import lfmc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head,
   output logic   full,
   output logic   empty
);

   op_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrW:0]    count_ff;

   assign full  = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
      end
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("op queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("op queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("count slip");

endmodule

### hdl/lfmc_aes.sv
// ----------------------------------------------------------------------------
// lfmc_aes
// iterative aes-128 encryption, one round per cycle
// ----------------------------------------------------------------------------
module lfmc_aes import lfmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] din,
   input  logic [127:0] key,
   output logic         busy,
   output logic         done,
   output logic [127:0] dout
);

   logic         busy_ff;
   logic         done_ff;
   logic [3:0]   round_ff;
   logic [7:0]   rcon_ff;
   logic [127:0] state_ff;
   logic [127:0] rkey_ff;
   logic [127:0] rkey_next;
   logic         last;

   assign last      = (round_ff == 4'd10);
   assign rkey_next = next_round_key(rkey_ff, rcon_ff);
   assign busy      = busy_ff;
   assign done      = done_ff;
   assign dout      = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd1;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff  <= 1'b1;
            round_ff <= 4'd1;
         end else if (busy_ff) begin
            round_ff <= round_ff + 4'd1;
            if (last) busy_ff <= 1'b0;
         end
      end
      if (start) begin
         state_ff <= din ^ key;
         rkey_ff  <= key;
         rcon_ff  <= 8'h01;
      end else if (busy_ff) begin
         state_ff <= aes_round(state_ff, last) ^ rkey_next;
         rkey_ff  <= rkey_next;
         rcon_ff  <= xtime(rcon_ff);
      end
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("aes started while busy");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("stray done");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> round_ff >= 4'd1 && round_ff <= 4'd10) else $error("round range");

endmodule

### hdl/lfmc_back.sv
// ----------------------------------------------------------------------------
// lfmc_back
// runs queued ops: subkey derivation, cbc chaining and the final mic block
// ----------------------------------------------------------------------------
module lfmc_back import lfmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [127:0] key,
   input  op_type       head,
   input  logic         empty,
   output logic         pop,
   input  logic         rsp_pop,
   output logic         rsp_valid,
   output logic [31:0]  mic
);

   typedef enum logic [1:0] {
      S_IDLE, S_SUBKEY, S_LAUNCH, S_RUN
   } state_type;

   state_type    state_ff, state_in;
   logic [127:0] chain_ff, k1_ff, k2_ff, b0_ff;
   logic         zero_len_ff, final_ff, final_in;
   logic         rsp_valid_ff;
   logic [31:0]  mic_ff;
   logic         aes_start, aes_busy, aes_done;
   logic [127:0] aes_din, aes_dout;
   logic [127:0] k1_new;

   assign k1_new    = gf_double(aes_dout);
   assign rsp_valid = rsp_valid_ff;
   assign mic       = mic_ff;

   lfmc_aes u_aes (
      .clock (clock),
      .reset (reset),
      .start (aes_start),
      .din   (aes_din),
      .key   (key),
      .busy  (aes_busy),
      .done  (aes_done),
      .dout  (aes_dout)
   );

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      pop       = 1'b0;
      aes_start = 1'b0;
      aes_din   = head.blk ^ chain_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               unique case (head.kind)
                  OP_START: begin
                     pop       = 1'b1;
                     aes_start = 1'b1;
                     aes_din   = '0;
                     state_in  = S_SUBKEY;
                  end
                  OP_BLOCK: begin
                     pop       = 1'b1;
                     aes_start = 1'b1;
                     final_in  = 1'b0;
                     state_in  = S_RUN;
                  end
                  OP_FINAL: begin
                     // result slot must be free before the last block runs
                     if (!rsp_valid_ff) begin
                        pop       = 1'b1;
                        aes_start = 1'b1;
                        aes_din   = head.blk ^ chain_ff ^ (head.use_k2 ? k2_ff : k1_ff);
                        final_in  = 1'b1;
                        state_in  = S_RUN;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         S_SUBKEY: begin
            if (aes_done) state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            // chain is zero here, b0 is the first block
            aes_din = zero_len_ff ? (b0_ff ^ k1_ff) : b0_ff;
            if (!zero_len_ff || !rsp_valid_ff) begin
               aes_start = 1'b1;
               final_in  = zero_len_ff;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            if (aes_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         final_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         if (rsp_pop && rsp_valid_ff) rsp_valid_ff <= 1'b0;
         if (state_ff == S_IDLE && pop && head.kind == OP_START) begin
            chain_ff <= '0;
         end
         if (state_ff == S_RUN && aes_done) begin
            if (final_ff) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               chain_ff <= aes_dout;
            end
         end
      end
      if (state_ff == S_IDLE && pop && head.kind == OP_START) begin
         b0_ff       <= head.blk;
         zero_len_ff <= head.zero_len;
      end
      if (state_ff == S_SUBKEY && aes_done) begin
         k1_ff <= k1_new;
         k2_ff <= gf_double(k1_new);
      end
      if (state_ff == S_RUN && aes_done && final_ff) begin
         mic_ff <= {aes_dout[103:96], aes_dout[111:104], aes_dout[119:112],
                    aes_dout[127:120]};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pop |=> rsp_valid_ff) else $error("result dropped");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RUN && final_ff && aes_done))
      else $error("result without final block");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      aes_start |-> !aes_busy) else $error("aes start while busy");

endmodule

### hdl/lorawan_frame_mic_cmac.sv
// ----------------------------------------------------------------------------
// lorawan_frame_mic_cmac
// lorawan frame mic as aes-128-cmac over b0 and the message bytes
// ----------------------------------------------------------------------------
// usage:
//   load the network session key through the csr port (key_high at 0x0,
//   key_low at 0x8, 64-bit data) while the block is idle.
//   push a start transaction (req_type 0) with direction, dev_addr,
//   frame_counter and msg_length, then msg_length data transactions
//   (req_type 1), one byte each. data with no open message is dropped, a
//   new start abandons an open message.
//   the mic appears on the rsp side when rsp_empty is low and stays until
//   popped. a zero length message yields its mic from the start alone.
// timing:
//   requests are taken one per cycle while req_full is low. the back end
//   has one iterative aes core: a start runs it for the subkeys and then
//   for b0, each further block runs it once. a 4-op queue parts front and
//   back; req_full rises when it fills. a stalled receiver holds only the
//   final block of the next message.
//   reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lorawan_frame_mic_cmac import lfmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic         req_type,
   input  logic         req_direction,
   input  logic [31:0]  req_dev_addr,
   input  logic [15:0]  req_frame_counter,
   input  logic [7:0]   req_msg_length,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [31:0]  rsp_mic,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        accept;
   logic        op_push, q_full, q_empty, q_pop;
   op_type      op, head;
   logic        rsp_valid;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[3] ? key_low_ff : key_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[3]) key_low_ff  <= csr_pwdata;
         else              key_high_ff <= csr_pwdata;
      end
   end

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign rsp_empty = !rsp_valid;

   lfmc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .direction     (req_direction),
      .dev_addr      (req_dev_addr),
      .frame_counter (req_frame_counter),
      .msg_length    (req_msg_length),
      .data_byte     (req_data_byte),
      .op_push       (op_push),
      .op            (op)
   );

   lfmc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .push_op (op),
      .pop     (q_pop),
      .head    (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   lfmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       ({key_high_ff, key_low_ff}),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .mic       (rsp_mic)
   );

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !accept) else $error("request taken while full");
   a_mic_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_mic)) else $error("mic changed");
   a_csr_ready: assert property (@(posedge clock) csr_pready)
      else $error("csr not ready");

endmodule

### verif/lfmc_mic_checker.sv
// ----------------------------------------------------------------------------
// lfmc_mic_checker
// watches the request, response and csr channels of the frame mic engine,
// computes the expected mic of every finished frame and compares it with the response
// ----------------------------------------------------------------------------
module lfmc_mic_checker import lfmc_pkg::*; #(
   parameter logic [3:0] KeyHighAddr = 4'h0,
   parameter logic [3:0] KeyLowAddr  = 4'h8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_type,
   input  logic        req_direction,
   input  logic [31:0] req_dev_addr,
   input  logic [15:0] req_frame_counter,
   input  logic [7:0]  req_msg_length,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_mic,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mic_errors,
   output int          mic_pending
);

   logic [7:0]   sub_table [256];
   logic [63:0]  nwk_key_high, nwk_key_low;
   logic [127:0] chain_block, msg_block, k1_key, k2_key;
   int           block_fill;
   logic [7:0]   bytes_left;
   logic         frame_open;
   logic [31:0]  expected_mics [$];

   function automatic logic [7:0] mul_x(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = mul_x(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   // s-box from the field inverse and the affine map
   initial begin
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int c = 1; c < 256; c++) begin
            if (gf_mul(a[7:0], c[7:0]) == 8'h01) inv = c[7:0];
         end
         sub_table[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                        ^ rotl8(inv, 4) ^ 8'h63;
      end
   end

   // byte i of a block at bits 127-8i downto 120-8i
   function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   rk [16];
      logic [7:0]   rcon, a0, a1, a2, a3, all;
      logic [127:0] key, ct;
      key  = {nwk_key_high, nwk_key_low};
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127 - 8*i -: 8];
         s[i]  = pt[127 - 8*i -: 8] ^ rk[i];
      end
      for (int round = 1; round <= 10; round++) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               t[r + 4*c] = sub_table[s[r + 4*((c + r) % 4)]];
            end
         end
         if (round < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ all ^ mul_x(a0 ^ a1);
               t[4*c+1] = a1 ^ all ^ mul_x(a1 ^ a2);
               t[4*c+2] = a2 ^ all ^ mul_x(a2 ^ a3);
               t[4*c+3] = a3 ^ all ^ mul_x(a3 ^ a0);
            end
         end
         rk[0] = rk[0] ^ sub_table[rk[13]] ^ rcon;
         rk[1] = rk[1] ^ sub_table[rk[14]];
         rk[2] = rk[2] ^ sub_table[rk[15]];
         rk[3] = rk[3] ^ sub_table[rk[12]];
         for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
         rcon = mul_x(rcon);
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = s[i];
      return ct;
   endfunction

   function automatic logic [127:0] gf128_double(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   task automatic queue_mic(input logic [31:0] m);
      expected_mics = {expected_mics, m};
   endtask

   // final cmac block, mic is the first four output bytes, byte 0 lowest
   function automatic logic [31:0] final_mic(input logic [127:0] blk,
                                             input logic [127:0] subkey);
      logic [127:0] o;
      o = aes_encrypt(blk ^ subkey ^ chain_block);
      return {o[103:96], o[111:104], o[119:112], o[127:120]};
   endfunction

   task automatic advance_frame(input logic kind, input logic dir,
                                input logic [31:0] addr, input logic [15:0] fcnt,
                                input logic [7:0] len, input logic [7:0] data);
      logic [127:0] b0, last;
      if (kind == REQ_START) begin
         k1_key = gf128_double(aes_encrypt(128'h0));
         k2_key = gf128_double(k1_key);
         b0 = {B0Tag, 32'h0, 7'h0, dir, addr, fcnt[7:0], fcnt[15:8], 24'h0, len};
         chain_block = '0;
         block_fill  = 0;
         if (len == 8'd0) begin
            // empty message: b0 alone is the last complete block
            frame_open = 1'b0;
            bytes_left = 8'd0;
            queue_mic(final_mic(b0, k1_key));
         end else begin
            chain_block = aes_encrypt(b0);
            bytes_left  = len;
            frame_open  = 1'b1;
         end
      end else if (frame_open) begin
         msg_block[127 - 8*block_fill -: 8] = data;
         block_fill = block_fill + 1;
         bytes_left = bytes_left - 8'd1;
         if (bytes_left == 8'd0) begin
            frame_open = 1'b0;
            if (block_fill >= 16) begin
               queue_mic(final_mic(msg_block, k1_key));
            end else begin
               last = msg_block;
               for (int i = block_fill; i < 16; i++) begin
                  last[127 - 8*i -: 8] = (i == block_fill) ? PadByte : 8'h00;
               end
               queue_mic(final_mic(last, k2_key));
            end
            block_fill = 0;
         end else if (block_fill >= 16) begin
            chain_block = aes_encrypt(msg_block ^ chain_block);
            block_fill  = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         nwk_key_high = '0;
         nwk_key_low  = '0;
         chain_block  = '0;
         block_fill   = 0;
         bytes_left   = '0;
         frame_open   = 1'b0;
         expected_mics.delete();
         mic_errors   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == KeyHighAddr) nwk_key_high = csr_pwdata;
            else if (csr_paddr == KeyLowAddr) nwk_key_low = csr_pwdata;
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_mics.size() == 0) begin
               $error("unexpected mic transaction: actual %h", rsp_mic);
               mic_errors = mic_errors + 1;
            end else begin
               want = expected_mics.pop_front();
               if (rsp_mic !== want) begin
                  $error("mic mismatch: expected %h actual %h", want, rsp_mic);
                  mic_errors = mic_errors + 1;
               end
            end
         end
         if (req_push && !req_full) begin
            advance_frame(req_type, req_direction, req_dev_addr, req_frame_counter,
                          req_msg_length, req_data_byte);
         end
      end
      mic_pending = expected_mics.size();
   end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// frame mic engine test: loads several keys, sends directed and random frames
// with random gaps on both sides, and lets the checker compare every mic
// ----------------------------------------------------------------------------
module testbench;
   import lfmc_pkg::*;

   localparam logic [3:0] KeyHighAddr = 4'h0;
   localparam logic [3:0] KeyLowAddr  = 4'h8;
   localparam int HoldCycles  = 400;
   localparam int StallLimit  = 4000;
   localparam int DrainCycles = 200;
   localparam int PhaseItems  = 340;

   logic        clock, reset;
   logic        req_push, req_full, req_type, req_direction;
   logic [31:0] req_dev_addr;
   logic [15:0] req_frame_counter;
   logic [7:0]  req_msg_length, req_data_byte;
   logic        rsp_empty, rsp_pop;
   logic [31:0] rsp_mic;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;
   int          mic_errors, mic_pending;
   int          items_sent;
   bit          hold_rsp, req_burst, rsp_burst;

   lorawan_frame_mic_cmac dut (.*);

   lfmc_mic_checker #(.KeyHighAddr(KeyHighAddr), .KeyLowAddr(KeyLowAddr)) mic_check (
      .clock, .reset, .req_push, .req_full, .req_type, .req_direction,
      .req_dev_addr, .req_frame_counter, .req_msg_length, .req_data_byte,
      .rsp_empty, .rsp_pop, .rsp_mic, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr, .csr_pwdata, .csr_pready, .mic_errors, .mic_pending
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ends the run when nothing moves for too long
   initial begin
      int stall;
      stall = 0;
      while (stall < StallLimit) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel)
            stall = 0;
         else
            stall = stall + 1;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int gap, served;
      rsp_pop = 1'b0;
      served  = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop = 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (served % 48 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         gap = rsp_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         served = served + 1;
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = addr; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic send_item(input req_kind_type kind, input logic dir,
                            input logic [31:0] addr, input logic [15:0] fcnt,
                            input logic [7:0] len, input logic [7:0] data);
      int gap;
      @(negedge clock);
      if (items_sent % 64 == 0) req_burst = ($urandom_range(0, 3) == 0);
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type = kind; req_direction = dir; req_dev_addr = addr;
      req_frame_counter = fcnt; req_msg_length = len; req_data_byte = data;
      req_push = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   task automatic send_start(input logic dir, input logic [31:0] addr,
                             input logic [15:0] fcnt, input logic [7:0] len);
      send_item(REQ_START, dir, addr, fcnt, len, $urandom_range(0, 255));
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_item(REQ_DATA, $urandom_range(0, 1), $urandom, $urandom_range(0, 65535),
                $urandom_range(0, 255), data);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // sends the start and the first sent_bytes of a frame of len bytes
   task automatic send_frame(input int len, input int sent_bytes);
      send_start($urandom_range(0, 1), $urandom, $urandom_range(0, 65535), len[7:0]);
      for (int i = 0; i < sent_bytes; i++) send_byte(pick_byte());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (mic_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_key(input logic [63:0] high, input logic [63:0] low);
      wait_drained();
      csr_write(KeyHighAddr, high);
      csr_write(KeyLowAddr, low);
   endtask

   task automatic random_frames(input int count);
      int stop, len, pick;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)       len = 255;
         else if (pick < 65) len = $urandom_range(0, 20);
         else                len = $urandom_range(17, 48);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_byte(pick_byte());
         end else if (pick < 12 && len > 0) begin
            send_frame(len, $urandom_range(0, len - 1));
         end else begin
            send_frame(len, len);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0; req_type = REQ_START; req_direction = 1'b0;
      req_dev_addr = '0; req_frame_counter = '0; req_msg_length = '0;
      req_data_byte = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      hold_rsp = 1'b0; req_burst = 1'b0; rsp_burst = 1'b0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames under the all-zero key
      load_key(64'h0, 64'h0);
      send_start(1'b0, 32'h0, 16'h0, 8'd0);
      send_start(1'b1, 32'hffff_ffff, 16'hffff, 8'd0);
      send_byte(8'h5a);                        // data with no open frame
      send_start(1'b0, 32'h1234_5678, 16'h00ff, 8'd1);
      send_byte(8'hff);
      send_start(1'b1, 32'h8000_0001, 16'hff00, 8'd10);
      send_byte(8'h00);
      send_byte(8'hff);
      send_start(1'b0, 32'hdead_beef, 16'h1234, 8'd16);  // abandons the open frame
      for (int i = 0; i < 16; i++) send_byte(i[0] ? 8'hff : 8'h00);

      load_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      send_frame(255, 255);
      random_frames(PhaseItems);

      // receiver stalls while short frames pile up behind it
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) send_frame($urandom_range(0, 2), 0);
      random_frames(PhaseItems);

      load_key({$urandom, $urandom}, 64'h0);
      random_frames(PhaseItems);
      load_key(64'h0, {$urandom, $urandom});
      random_frames(PhaseItems);
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      random_frames(PhaseItems);

      wait_drained();
      if (mic_errors == 0 && mic_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
